[rtl/core/line_follow_pid_steering_assert.svh]
// Assertion macros for the line follower steering block.
// Used by the checker; needs nothing else.
`ifndef LINE_FOLLOW_PID_STEERING_ASSERT_SVH
`define LINE_FOLLOW_PID_STEERING_ASSERT_SVH

// clocked assertion, switched off while reset is high
`define LFPS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds during reset
`define LFPS_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/lfps_pkg.sv]
// Shared types, constants and the sensor pattern decoder of the steering block.
// No dependencies.
`default_nettype none

package lfps_pkg;

   localparam int SPEED_W = 10;
   localparam int GAIN_W  = 16;
   localparam int ILIM_W  = 9;
   localparam int PAT_W   = 5;
   localparam int ERR_W   = 4;
   localparam int SUM_W   = 10;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [GAIN_W-1:0]  GAIN_P_RST   = 16'd461;
   localparam logic [GAIN_W-1:0]  GAIN_I_RST   = 16'd8;
   localparam logic [GAIN_W-1:0]  GAIN_D_RST   = 16'd154;
   localparam logic [ILIM_W-1:0]  ILIM_RST     = 9'd400;
   localparam logic [SPEED_W-1:0] ALIM_RST     = 10'd280;
   localparam logic [SPEED_W-1:0] FLOOR_RST    = 10'd150;
   localparam logic [SPEED_W-1:0] CEILING_RST  = 10'd800;

   localparam logic [SPEED_W-1:0] BASE_CURVE    = 10'd450;
   localparam logic [SPEED_W-1:0] BASE_STRAIGHT = 10'd550;
   localparam logic [SPEED_W-1:0] BASE_LOST     = 10'd250;
   localparam logic [SPEED_W-1:0] BASE_CROSS    = 10'd500;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAIN_P  = 3'd0,
      CSR_GAIN_I  = 3'd1,
      CSR_GAIN_D  = 3'd2,
      CSR_ILIM    = 3'd3,
      CSR_ALIM    = 3'd4,
      CSR_FLOOR   = 3'd5,
      CSR_CEILING = 3'd6
   } csr_index_type;

   typedef enum logic {
      CMD_SAMPLE = 1'b0,
      CMD_CLEAR  = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      CLS_STRAIGHT = 2'd0,
      CLS_CURVE    = 2'd1,
      CLS_LOST     = 2'd2,
      CLS_CROSSING = 2'd3
   } path_type;

   typedef struct packed {
      logic [GAIN_W-1:0]  gain_p;
      logic [GAIN_W-1:0]  gain_i;
      logic [GAIN_W-1:0]  gain_d;
      logic [ILIM_W-1:0]  integral_limit;
      logic [SPEED_W-1:0] adjust_limit;
      logic [SPEED_W-1:0] speed_floor;
      logic [SPEED_W-1:0] speed_ceiling;
   } cfg_type;

   typedef struct packed {
      logic signed [ERR_W-1:0] prev_err;
      logic signed [SUM_W-1:0] err_sum;
   } ctrl_state_type;

   typedef struct packed {
      logic [SPEED_W-1:0] wheel_left;
      logic [SPEED_W-1:0] wheel_right;
      path_type           path_class;
   } result_type;

   typedef struct packed {
      logic signed [ERR_W-1:0] err;
      path_type                cls;
      logic [SPEED_W-1:0]      base;
   } class_type;

   function automatic class_type classify(logic [PAT_W-1:0] pat, logic prev_pos);
      class_type c;
      c.err  = 4'sd0;
      c.cls  = CLS_CURVE;
      c.base = BASE_CURVE;
      unique case (pat)
         5'h00: begin
            c.err  = prev_pos ? 4'sd4 : -4'sd4;
            c.cls  = CLS_LOST;
            c.base = BASE_LOST;
         end
         5'h04: begin
            c.cls  = CLS_STRAIGHT;
            c.base = BASE_STRAIGHT;
         end
         5'h02, 5'h06:        c.err = -4'sd1;
         5'h01, 5'h03, 5'h07: c.err = -4'sd3;
         5'h08, 5'h0C:        c.err = 4'sd1;
         5'h10, 5'h18, 5'h1C: c.err = 4'sd3;
         5'h1F, 5'h0E: begin
            c.cls  = CLS_CROSSING;
            c.base = BASE_CROSS;
         end
         default: begin
            if (|pat[1:0]) begin
               c.err = -4'sd2;
            end else if (|pat[4:3]) begin
               c.err = 4'sd2;
            end
         end
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

[rtl/core/lfps_req_if.sv]
// Sample channel: valid/ready handshake with command and sensor pattern.
// Depends on lfps_pkg.
`default_nettype none

interface lfps_req_if;
   import lfps_pkg::*;

   logic             valid;
   logic             ready;
   logic             command;
   logic [PAT_W-1:0] sensor_pattern;

   modport source (output valid, output command, output sensor_pattern, input ready);
   modport sink   (input valid, input command, input sensor_pattern, output ready);
endinterface

`default_nettype wire

[rtl/core/lfps_rsp_if.sv]
// Result channel: valid/ready handshake with wheel speeds and path class.
// Depends on lfps_pkg.
`default_nettype none

interface lfps_rsp_if;
   import lfps_pkg::*;

   logic               valid;
   logic               ready;
   logic [SPEED_W-1:0] wheel_left;
   logic [SPEED_W-1:0] wheel_right;
   logic [1:0]         path_class;

   modport source (output valid, output wheel_left, output wheel_right, output path_class,
                   input ready);
   modport sink   (input valid, input wheel_left, input wheel_right, input path_class,
                   output ready);
endinterface

`default_nettype wire

[rtl/core/lfps_calc.sv]
// Single-pass PID datapath: decode, integral clamp, Q19.8 sum, adjust and speed clamps.
// Depends on lfps_pkg.
`default_nettype none

module lfps_calc (
   input  wire logic [lfps_pkg::PAT_W-1:0] sensor_pattern,
   input  wire lfps_pkg::ctrl_state_type   state_cur,
   input  wire lfps_pkg::cfg_type          cfg,
   output      lfps_pkg::ctrl_state_type   state_next,
   output      lfps_pkg::result_type       result
);
   import lfps_pkg::*;

   class_type          dec;
   logic signed [10:0] sum_raw;
   logic signed [10:0] ilim_s;
   logic signed [10:0] sum_clamp;
   logic signed [9:0]  sum_new;
   logic signed [4:0]  diff;
   logic signed [16:0] gp_s;
   logic signed [16:0] gi_s;
   logic signed [16:0] gd_s;
   logic signed [20:0] p_term;
   logic signed [26:0] i_term;
   logic signed [21:0] d_term;
   logic signed [27:0] adj;
   logic signed [27:0] adj_bias;
   logic signed [19:0] q;
   logic signed [19:0] alim_s;
   logic signed [10:0] q_clamp;
   logic signed [11:0] left_raw;
   logic signed [11:0] right_raw;
   logic signed [11:0] floor_s;
   logic signed [11:0] ceil_s;

   function automatic logic [SPEED_W-1:0] clamp_speed(logic signed [11:0] v,
                                                       logic signed [11:0] lo,
                                                       logic signed [11:0] hi);
      logic [SPEED_W-1:0] r;
      priority if (v < lo) begin
         r = lo[SPEED_W-1:0];
      end else if (v > hi) begin
         r = hi[SPEED_W-1:0];
      end else begin
         r = v[SPEED_W-1:0];
      end
      return r;
   endfunction

   always_comb begin
      dec = classify(sensor_pattern, (state_cur.prev_err > 4'sd0));

      sum_raw = 11'(dec.err) + 11'(state_cur.err_sum);
      ilim_s  = $signed({2'b00, cfg.integral_limit});
      priority if (sum_raw > ilim_s) begin
         sum_clamp = ilim_s;
      end else if (sum_raw < -ilim_s) begin
         sum_clamp = -ilim_s;
      end else begin
         sum_clamp = sum_raw;
      end
      sum_new = sum_clamp[9:0];

      diff = 5'(dec.err) - 5'(state_cur.prev_err);

      gp_s   = $signed({1'b0, cfg.gain_p});
      gi_s   = $signed({1'b0, cfg.gain_i});
      gd_s   = $signed({1'b0, cfg.gain_d});
      p_term = gp_s * dec.err;
      i_term = gi_s * sum_new;
      d_term = gd_s * diff;
      adj    = 28'(p_term) + 28'(i_term) + 28'(d_term);

      // truncate toward zero
      adj_bias = adj[27] ? (adj + 28'sd255) : adj;
      q        = adj_bias[27:8];

      alim_s = $signed({10'b0, cfg.adjust_limit});
      priority if (q > alim_s) begin
         q_clamp = alim_s[10:0];
      end else if (q < -alim_s) begin
         q_clamp = 11'(-alim_s);
      end else begin
         q_clamp = q[10:0];
      end

      left_raw  = $signed({2'b00, dec.base}) - 12'(q_clamp);
      right_raw = $signed({2'b00, dec.base}) + 12'(q_clamp);
      floor_s   = $signed({2'b00, cfg.speed_floor});
      ceil_s    = $signed({2'b00, cfg.speed_ceiling});

      result.wheel_left  = clamp_speed(left_raw, floor_s, ceil_s);
      result.wheel_right = clamp_speed(right_raw, floor_s, ceil_s);
      result.path_class  = dec.cls;

      state_next.prev_err = dec.err;
      state_next.err_sum  = sum_new;
   end

endmodule

`default_nettype wire

[rtl/core/line_follow_pid_steering.sv]
// Top level of the line follower PID steering block: input register, datapath, result register.
// Depends on lfps_pkg, lfps_req_if, lfps_rsp_if and lfps_calc.
//
// Takes one transaction per clock cycle while the result is not stalled. The input register and
// the result register bound a single-pass datapath: a sample moves from the input register
// through the datapath into the result register, which raises the result valid. The integral
// and last error update in the same cycle that a sample leaves the input register; a stalled
// result holds the next sample in the input register. A clear command passes through the
// input register without waiting on the result, resets the integral and last error, and
// returns nothing. Configuration writes through csr_ take effect on the next sample and are
// meant for idle periods; an index past the register list is ignored.
`default_nettype none

module line_follow_pid_steering (
   input  wire logic                           clock,
   input  wire logic                           reset,
   lfps_req_if.sink                            req_bus,
   lfps_rsp_if.source                          rsp_bus,
   input  wire logic                           csr_write_enable,
   input  wire logic [lfps_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [lfps_pkg::CSR_DATA_W-1:0] csr_write_data
);
   import lfps_pkg::*;

   cfg_type            cfg_ff, cfg_in;
   logic               s1_valid_ff, s1_valid_in;
   cmd_type            s1_cmd_ff;
   logic [PAT_W-1:0]   s1_pat_ff;
   ctrl_state_type     state_ff, state_in;
   logic               out_valid_ff, out_valid_in;
   result_type         out_ff;

   ctrl_state_type     state_calc;
   result_type         result_calc;
   logic               req_accept;
   logic               out_free;
   logic               s1_adv;

   lfps_calc u_calc (
      .sensor_pattern (s1_pat_ff),
      .state_cur      (state_ff),
      .cfg            (cfg_ff),
      .state_next     (state_calc),
      .result         (result_calc)
   );

   assign out_free   = !out_valid_ff || rsp_bus.ready;
   assign s1_adv     = s1_valid_ff && ((s1_cmd_ff == CMD_CLEAR) || out_free);
   assign req_bus.ready = !s1_valid_ff || s1_adv;
   assign req_accept = req_bus.valid && req_bus.ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_GAIN_P:  cfg_in.gain_p         = csr_write_data;
            CSR_GAIN_I:  cfg_in.gain_i         = csr_write_data;
            CSR_GAIN_D:  cfg_in.gain_d         = csr_write_data;
            CSR_ILIM:    cfg_in.integral_limit = csr_write_data[ILIM_W-1:0];
            CSR_ALIM:    cfg_in.adjust_limit   = csr_write_data[SPEED_W-1:0];
            CSR_FLOOR:   cfg_in.speed_floor    = csr_write_data[SPEED_W-1:0];
            CSR_CEILING: cfg_in.speed_ceiling  = csr_write_data[SPEED_W-1:0];
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end

      state_in = state_ff;
      if (s1_adv) begin
         state_in = (s1_cmd_ff == CMD_CLEAR) ? '0 : state_calc;
      end

      out_valid_in = out_valid_ff;
      if (s1_adv && (s1_cmd_ff == CMD_SAMPLE)) begin
         out_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_p         <= GAIN_P_RST;
         cfg_ff.gain_i         <= GAIN_I_RST;
         cfg_ff.gain_d         <= GAIN_D_RST;
         cfg_ff.integral_limit <= ILIM_RST;
         cfg_ff.adjust_limit   <= ALIM_RST;
         cfg_ff.speed_floor    <= FLOOR_RST;
         cfg_ff.speed_ceiling  <= CEILING_RST;
         s1_valid_ff           <= 1'b0;
         state_ff              <= '0;
         out_valid_ff          <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         s1_valid_ff  <= s1_valid_in;
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload: load only, no reset
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_cmd_ff <= cmd_type'(req_bus.command);
         s1_pat_ff <= req_bus.sensor_pattern;
      end
      if (s1_adv && (s1_cmd_ff == CMD_SAMPLE)) begin
         out_ff <= result_calc;
      end
   end

   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.wheel_left  = out_ff.wheel_left;
   assign rsp_bus.wheel_right = out_ff.wheel_right;
   assign rsp_bus.path_class  = out_ff.path_class;

endmodule

`default_nettype wire

[rtl/core/lfps_checker.sv]
// Port-level checker for line_follow_pid_steering, attached by bind.
// Depends on lfps_pkg and line_follow_pid_steering_assert.svh.
`default_nettype none

`include "line_follow_pid_steering_assert.svh"

module lfps_checker (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         req_valid,
   input wire logic                         req_ready,
   input wire logic                         req_command,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_ready,
   input wire logic [lfps_pkg::SPEED_W-1:0] rsp_wheel_left,
   input wire logic [lfps_pkg::SPEED_W-1:0] rsp_wheel_right,
   input wire logic [1:0]                   rsp_path_class
);
   import lfps_pkg::*;

   logic                 sample_acc;
   logic                 stall;
   logic [2*SPEED_W+1:0] payload;
   assign sample_acc = req_valid && req_ready && (req_command == CMD_SAMPLE);
   assign stall      = rsp_valid && !rsp_ready;
   assign payload    = {rsp_wheel_left, rsp_wheel_right, rsp_path_class};

   `LFPS_ASSERT_ALWAYS(a_reset_empties, clock, reset |=> !rsp_valid, "result valid after reset")
   `LFPS_ASSERT(a_valid_holds, clock, reset, stall |=> rsp_valid, "result dropped in stall")
   `LFPS_ASSERT(a_payload_holds, clock, reset, stall |=> $stable(payload), "payload changed")
   `LFPS_ASSERT(a_sourced, clock, reset, $rose(rsp_valid) |-> $past(sample_acc, 2), "orphan result")

endmodule

bind line_follow_pid_steering lfps_checker u_lfps_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .req_command     (req_bus.command),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_wheel_left  (rsp_bus.wheel_left),
   .rsp_wheel_right (rsp_bus.wheel_right),
   .rsp_path_class  (rsp_bus.path_class)
);

`default_nettype wire
